[sv/assert_macros.svh]
// Assertion macros for the joystick drive mixer.
// Needs clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge out of reset.
`define JDM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication checked on every clock edge out of reset.
`define JDM_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[sv/jdm_pkg.sv]
// Shared constants, mode codes and width helpers for the joystick drive mixer.
// No dependencies.
package jdm_pkg;

	// Deadband around the converter center
	localparam int CENTRE    = 510;
	localparam int BAND      = 25;
	localparam int LOW_EDGE  = CENTRE - BAND;
	localparam int HIGH_EDGE = CENTRE + BAND;

	// Full-scale command and the 0.95 full-throttle limit as 19/20
	localparam int FULL_CMD = 127;
	localparam int FULL_NUM = 20;
	localparam int FULL_DEN = 19;

	// Command and pipeline geometry
	localparam int CMD_BITS   = 8;
	localparam int QBITS      = 7;
	localparam int NUM_LANES  = 3;
	localparam int LANE_X     = 0;
	localparam int LANE_Y     = 1;
	localparam int LANE_YAW   = 2;
	localparam int MIX_STAGES = 4;

	// Register indexes on the config port
	localparam logic [0:0] REG_INPUT_MODE = 1'b0;
	localparam logic [0:0] REG_DRIVE_MODE = 1'b1;

	typedef enum logic [1:0] {
		IN_ARCADE2 = 2'b00,
		IN_ARCADE1 = 2'b01,
		IN_TANK    = 2'b10
	} in_mode_t;

	typedef enum logic [1:0] {
		DRV_HALF = 2'b00,
		DRV_3Q   = 2'b01,
		DRV_FULL = 2'b10
	} drv_mode_t;

	// Width of a deflection magnitude or denominator (485 needs 9 bits)
	function automatic int data_bits(input int sb);
		return (sb > 9) ? sb : 9;
	endfunction

	// Width of a divider numerator: 127 times a mixed magnitude
	function automatic int num_bits(input int sb);
		return 2 * data_bits(sb) + 8;
	endfunction

	// Width of a divider denominator: twice a product of two denominators
	function automatic int den_bits(input int sb);
		return 2 * data_bits(sb) + 1;
	endfunction

endpackage

[sv/jdm_mix.sv]
// Front end of the mixer: deadband, tank cross products, sum/difference and
// operand selection for the three divider lanes. Four register stages.
// Depends on jdm_pkg.
module jdm_mix #(
	parameter int SAMPLE_BITS = 10,
	localparam int DW  = jdm_pkg::data_bits(SAMPLE_BITS),
	localparam int NW  = jdm_pkg::num_bits(SAMPLE_BITS),
	localparam int DNW = jdm_pkg::den_bits(SAMPLE_BITS)
) (
	input  logic                    clk,
	input  logic [jdm_pkg::MIX_STAGES-1:0] en,
	input  jdm_pkg::in_mode_t       input_mode,
	input  logic [SAMPLE_BITS-1:0]  stick1_x,
	input  logic [SAMPLE_BITS-1:0]  stick1_y,
	input  logic [SAMPLE_BITS-1:0]  stick2_x,
	input  logic [SAMPLE_BITS-1:0]  stick2_y,
	output logic [NW-1:0]           num_s4 [jdm_pkg::NUM_LANES],
	output logic [DNW-1:0]          den_s4 [jdm_pkg::NUM_LANES],
	output logic                    neg_s4 [jdm_pkg::NUM_LANES]
);
	import jdm_pkg::*;

	localparam int SMAX   = (1 << SAMPLE_BITS) - 1;
	localparam int D_HIGH = (SMAX > HIGH_EDGE) ? SMAX - HIGH_EDGE : 1;
	localparam int PW     = 2 * DW;
	localparam int SW     = 2 * DW + 2;
	localparam int MW     = SW - 1;

	// Sample places: L and R of tank mode are stick1_x and stick2_x
	localparam int SMP_L = 0;
	localparam int SMP_Y = 1;
	localparam int SMP_R = 2;
	localparam int SMP_T = 3;

	logic [SAMPLE_BITS-1:0] smp [4];
	logic [31:0]            v_w [4];
	logic [DW-1:0]          nm_c [4];
	logic [DW-1:0]          d_c [4];
	logic [3:0]             below_c, above_c, full_c;

	logic [DW-1:0] nm_s1 [4];
	logic [DW-1:0] d_s1 [4];
	logic [3:0]    neg_s1, nz_s1, fp_s1, fn_s1;

	logic [PW-1:0] a_s2, b_s2, den_s2;
	logic [DW-1:0] nm_s2 [4];
	logic [DW-1:0] d_s2 [4];
	logic [3:0]    neg_s2, nz_s2, fp_s2, fn_s2;

	logic signed [SW-1:0] sa_c, sb_c;
	logic c1_c, c2_c, c3_c, c4_c;

	logic signed [SW-1:0] sum_s3, diff_s3;
	logic [PW-1:0]        den_s3;
	logic                 full_s3, fneg_s3;
	logic [DW-1:0]        nm_s3 [4];
	logic [DW-1:0]        d_s3 [4];
	logic [3:0]           neg_s3;

	logic [MW-1:0]  msum_c, mdiff_c;
	logic [NW-1:0]  num_c [NUM_LANES];
	logic [DNW-1:0] den_c [NUM_LANES];
	logic           neg_c [NUM_LANES];

	function automatic logic [NW-1:0] times_cmd(input logic [NW-1:0] m);
		return m * NW'(FULL_CMD);
	endfunction

	assign smp[0] = stick1_x;
	assign smp[1] = stick1_y;
	assign smp[2] = stick2_x;
	assign smp[3] = stick2_y;

	// Stage 1: deadband, deflection as magnitude/denominator, 0.95 test
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			v_w[i]     = 32'(smp[i]);
			below_c[i] = v_w[i] < 32'(LOW_EDGE);
			above_c[i] = v_w[i] > 32'(HIGH_EDGE);
			if (below_c[i]) begin
				nm_c[i] = DW'(32'(LOW_EDGE) - v_w[i]);
				d_c[i]  = DW'(LOW_EDGE);
			end else if (above_c[i]) begin
				nm_c[i] = DW'(v_w[i] - 32'(HIGH_EDGE));
				d_c[i]  = DW'(D_HIGH);
			end else begin
				nm_c[i] = '0;
				d_c[i]  = DW'(1);
			end
			full_c[i] = (32'(nm_c[i]) * 32'(FULL_NUM)) > (32'(d_c[i]) * 32'(FULL_DEN));
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 4; i++) begin
				nm_s1[i]  <= nm_c[i];
				d_s1[i]   <= d_c[i];
				neg_s1[i] <= above_c[i];
				nz_s1[i]  <= below_c[i] | above_c[i];
				fp_s1[i]  <= full_c[i] & ~above_c[i];
				fn_s1[i]  <= full_c[i] & above_c[i];
			end
		end
	end

	// Stage 2: tank cross products over a common denominator
	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s2   <= PW'(nm_s1[SMP_L]) * PW'(d_s1[SMP_R]);
			b_s2   <= PW'(nm_s1[SMP_R]) * PW'(d_s1[SMP_L]);
			den_s2 <= PW'(d_s1[SMP_L]) * PW'(d_s1[SMP_R]);
			nm_s2  <= nm_s1;
			d_s2   <= d_s1;
			neg_s2 <= neg_s1;
			nz_s2  <= nz_s1;
			fp_s2  <= fp_s1;
			fn_s2  <= fn_s1;
		end
	end

	// Stage 3: signed sum and difference, full-throttle cases in order
	always_comb begin
		sa_c = $signed(SW'(a_s2));
		sb_c = $signed(SW'(b_s2));
		if (neg_s2[SMP_L])
			sa_c = -sa_c;
		if (neg_s2[SMP_R])
			sb_c = -sb_c;
		c1_c = fp_s2[SMP_L] & ~neg_s2[SMP_R];
		c2_c = fn_s2[SMP_L] & ~(nz_s2[SMP_R] & ~neg_s2[SMP_R]);
		c3_c = fp_s2[SMP_R] & ~neg_s2[SMP_L];
		c4_c = fn_s2[SMP_R] & ~(nz_s2[SMP_L] & ~neg_s2[SMP_L]);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			sum_s3  <= sa_c + sb_c;
			diff_s3 <= sa_c - sb_c;
			den_s3  <= den_s2;
			full_s3 <= c1_c | c2_c | c3_c | c4_c;
			fneg_s3 <= ~c1_c & (c2_c | ~c3_c);
			nm_s3   <= nm_s2;
			d_s3    <= d_s2;
			neg_s3  <= neg_s2;
		end
	end

	// Stage 4: divider operands per lane, chosen by input mode
	always_comb begin
		msum_c  = (sum_s3 < 0) ? MW'(-sum_s3) : MW'(sum_s3);
		mdiff_c = (diff_s3 < 0) ? MW'(-diff_s3) : MW'(diff_s3);
		for (int l = 0; l < NUM_LANES; l++) begin
			num_c[l] = '0;
			den_c[l] = DNW'(1);
			neg_c[l] = 1'b0;
		end
		case (input_mode)
			IN_ARCADE2: begin
				num_c[LANE_X]   = times_cmd(NW'(nm_s3[SMP_L]));
				den_c[LANE_X]   = DNW'(d_s3[SMP_L]);
				neg_c[LANE_X]   = neg_s3[SMP_L];
				num_c[LANE_Y]   = times_cmd(NW'(nm_s3[SMP_Y]));
				den_c[LANE_Y]   = DNW'(d_s3[SMP_Y]);
				neg_c[LANE_Y]   = neg_s3[SMP_Y];
				num_c[LANE_YAW] = times_cmd(NW'(nm_s3[SMP_T]));
				den_c[LANE_YAW] = DNW'(d_s3[SMP_T]);
				neg_c[LANE_YAW] = neg_s3[SMP_T];
			end
			IN_ARCADE1: begin
				num_c[LANE_X]   = times_cmd(NW'(nm_s3[SMP_R]));
				den_c[LANE_X]   = DNW'(d_s3[SMP_R]);
				neg_c[LANE_X]   = neg_s3[SMP_R];
				num_c[LANE_YAW] = times_cmd(NW'(nm_s3[SMP_T]));
				den_c[LANE_YAW] = DNW'(d_s3[SMP_T]);
				neg_c[LANE_YAW] = neg_s3[SMP_T];
			end
			IN_TANK: begin
				num_c[LANE_YAW] = times_cmd(NW'(mdiff_c));
				neg_c[LANE_YAW] = diff_s3 < 0;
				if (full_s3) begin
					// full throttle: x pinned, yaw not halved
					num_c[LANE_X]   = NW'(FULL_CMD);
					neg_c[LANE_X]   = fneg_s3;
					den_c[LANE_YAW] = DNW'(den_s3);
				end else begin
					num_c[LANE_X]   = times_cmd(NW'(msum_c));
					den_c[LANE_X]   = {den_s3, 1'b0};
					neg_c[LANE_X]   = sum_s3 < 0;
					den_c[LANE_YAW] = {den_s3, 1'b0};
				end
			end
			default: begin
				num_c[LANE_X] = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			num_s4 <= num_c;
			den_s4 <= den_c;
			neg_s4 <= neg_c;
		end
	end

endmodule

[sv/jdm_div.sv]
// Pipelined restoring divider for one command lane: one quotient bit per
// stage, magnitude quotient below 128. Depends on jdm_pkg.
module jdm_div #(
	parameter int SAMPLE_BITS = 10,
	localparam int NW  = jdm_pkg::num_bits(SAMPLE_BITS),
	localparam int DNW = jdm_pkg::den_bits(SAMPLE_BITS)
) (
	input  logic                      clk,
	input  logic [jdm_pkg::QBITS-1:0] en,
	input  logic [NW-1:0]             num,
	input  logic [DNW-1:0]            den,
	input  logic                      neg,
	output logic [jdm_pkg::QBITS-1:0] quo,
	output logic                      quo_neg
);
	import jdm_pkg::*;

	logic [NW-1:0]    rem_s [1:QBITS-1];
	logic [DNW-1:0]   den_s [1:QBITS-1];
	logic [QBITS-1:0] quo_s [1:QBITS];
	logic             neg_s [1:QBITS];

	// One compare-subtract per stage, most significant quotient bit first
	for (genvar k = 0; k < QBITS; k++) begin : g_step
		localparam int SH = QBITS - 1 - k;
		logic [NW-1:0]    rem_in;
		logic [DNW-1:0]   den_in;
		logic [QBITS-1:0] quo_in;
		logic             neg_in;
		logic [NW-1:0]    trial;
		logic             ge;

		// First stage takes the lane operands, later ones the previous stage
		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
			assign neg_in = neg;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign den_in = den_s[k];
			assign quo_in = quo_s[k];
			assign neg_in = neg_s[k];
		end

		assign trial = NW'(den_in) << SH;
		assign ge    = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				quo_s[k+1] <= {quo_in[QBITS-2:0], ge};
				neg_s[k+1] <= neg_in;
			end
		end

		if (k < QBITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[k]) begin
					rem_s[k+1] <= ge ? rem_in - trial : rem_in;
					den_s[k+1] <= den_in;
				end
			end
		end
	end

	assign quo     = quo_s[QBITS];
	assign quo_neg = neg_s[QBITS];

endmodule

[sv/joystick_drive_mixer_top.sv]
// Joystick drive mixer top: 12 register stages, deadband and mixing (4),
// bit-per-stage division (7), power scaling into the output register (1).
// An input transaction passes through every stage to m_tvalid; one sample set
// per cycle is taken while no stall backs up, and stalls fill bubbles first.
// arst_n clears all stage valid bits and sets input_mode 0, drive_mode 2.
// Depends on jdm_pkg, jdm_mix, jdm_div and assert_macros.svh.
`include "assert_macros.svh"

module joystick_drive_mixer_top #(
	parameter int SAMPLE_BITS = 10,
	localparam int IN_BITS = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [0:0]         cfg_addr,
	input  logic [1:0]         cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	// stick1_x, stick1_y, stick2_x, stick2_y (SAMPLE_BITS each), zero pad
	input  logic [IN_BITS-1:0] s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// drive_x [7:0], drive_y [15:8], drive_yaw [23:16]
	output logic [23:0]        m_tdata
);
	import jdm_pkg::*;

	localparam int NSTAGES = MIX_STAGES + QBITS + 1;
	localparam int NW      = num_bits(SAMPLE_BITS);
	localparam int DNW     = den_bits(SAMPLE_BITS);

	in_mode_t  input_mode_q;
	drv_mode_t drive_mode_q;

	logic [NSTAGES-1:0] vld_q;
	logic [NSTAGES-1:0] en;

	logic [NW-1:0]    num_s4 [NUM_LANES];
	logic [DNW-1:0]   den_s4 [NUM_LANES];
	logic             neg_s4 [NUM_LANES];
	logic [QBITS-1:0] quo [NUM_LANES];
	logic             quo_neg [NUM_LANES];

	logic [QBITS+1:0]           x3_c [NUM_LANES];
	logic [QBITS-1:0]           mag_c [NUM_LANES];
	logic signed [CMD_BITS-1:0] cmd_c [NUM_LANES];
	logic signed [CMD_BITS-1:0] cmd_s12 [NUM_LANES];

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mode_q <= IN_ARCADE2;
			drive_mode_q <= DRV_FULL;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_INPUT_MODE: input_mode_q <= in_mode_t'(cfg_wdata);
				REG_DRIVE_MODE: drive_mode_q <= drv_mode_t'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Stage enables: a stage loads when empty or when the next one moves
	always_comb begin
		en[NSTAGES-1] = !vld_q[NSTAGES-1] || m_tready;
		for (int k = NSTAGES - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= s_tvalid;
			for (int k = 1; k < NSTAGES; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_q[NSTAGES-1];

	// Deadband, mixing and divider operands
	jdm_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix (
		.clk        (clk),
		.en         (en[MIX_STAGES-1:0]),
		.input_mode (input_mode_q),
		.stick1_x   (s_tdata[SAMPLE_BITS-1:0]),
		.stick1_y   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.stick2_x   (s_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
		.stick2_y   (s_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS]),
		.num_s4     (num_s4),
		.den_s4     (den_s4),
		.neg_s4     (neg_s4)
	);

	// One divider per command lane
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		jdm_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
			.clk     (clk),
			.en      (en[MIX_STAGES+QBITS-1:MIX_STAGES]),
			.num     (num_s4[l]),
			.den     (den_s4[l]),
			.neg     (neg_s4[l]),
			.quo     (quo[l]),
			.quo_neg (quo_neg[l])
		);
	end

	// Power scale on the magnitude, then restore the sign
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			x3_c[l] = (QBITS+2)'(quo[l]) * (QBITS+2)'(3);
			case (drive_mode_q)
				DRV_HALF: mag_c[l] = quo[l] >> 1;
				DRV_3Q:   mag_c[l] = QBITS'(x3_c[l] >> 2);
				DRV_FULL: mag_c[l] = quo[l];
				default:  mag_c[l] = quo[l];
			endcase
			cmd_c[l] = quo_neg[l] ? -$signed({1'b0, mag_c[l]}) : $signed({1'b0, mag_c[l]});
		end
	end

	always_ff @(posedge clk) begin
		if (en[NSTAGES-1])
			cmd_s12 <= cmd_c;
	end

	assign m_tdata = {cmd_s12[LANE_YAW], cmd_s12[LANE_Y], cmd_s12[LANE_X]};

	// Checks
	`JDM_ASSERT_IMPLY(a_stall_from_output, !s_tready, m_tvalid && !m_tready,
		"input stalled while the output side is free")
	`JDM_ASSERT_IMPLY(a_lateral_zero, m_tvalid && input_mode_q != IN_ARCADE2,
		cmd_s12[LANE_Y] == 8'sd0, "lateral command not zero outside two-stick arcade")
	`JDM_ASSERT_IMPLY(a_half_power, m_tvalid && drive_mode_q == DRV_HALF,
		cmd_s12[LANE_X] <= 8'sd63 && cmd_s12[LANE_X] >= -8'sd63,
		"half power command out of range")
	`JDM_ASSERT_ALWAYS(a_no_min_code, !m_tvalid || m_tdata[7:0] != 8'h80,
		"drive_x reached -128")

endmodule
